// ===== sv/page_framebuffer_draw_engine_top_macros.svh =====
// Assertion macros for the page frame buffer draw engine.
// Depends on nothing; included by the top level, which supplies clk and arst_n.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PFB_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("assertion failed");
`define PFB_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (c)) else $error("assertion failed");
`else
`define PFB_ASSERT_IMP(lbl, a, c)
`define PFB_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== sv/pfb_pkg.sv =====
// Shared types and constants of the page frame buffer draw engine.
// Depends on nothing.
`default_nettype none
package pfb_pkg;
	localparam int PAGES = 8;
	localparam int COLUMNS = 128;
	localparam int PAGE_W = 3;
	localparam int COL_W = 7;
	localparam int ADDR_W = PAGE_W + COL_W;
	localparam int DEPTH = PAGES * COLUMNS;

	localparam logic [1:0] KIND_DOT = 2'd0;
	localparam logic [1:0] KIND_COLUMN = 2'd1;
	localparam logic [1:0] KIND_RECT = 2'd2;
	localparam logic [1:0] KIND_FLUSH = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] row_from;
		logic [5:0] row_to;
		logic [6:0] col_from;
		logic [6:0] col_to;
		logic [7:0] value;
		logic [3:0] bit_count;
		logic [2:0] page;
	} in_item_t;

	typedef struct packed {
		logic [2:0] out_page;
		logic [6:0] first_col;
		logic [3:0] byte_count;
		logic [63:0] data;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic flush;
		logic [PAGE_W-1:0] p0;
		logic [PAGE_W-1:0] p1;
		logic [COL_W-1:0] c0;
		logic [COL_W-1:0] c1;
		logic [2:0] lo0;
		logic [2:0] hi1;
		logic [15:0] data16;
	} op_t;
endpackage
`default_nettype wire

// ===== sv/pfb_ram.sv =====
// Generic single write port, single registered read port RAM.
// Depends on nothing.
`default_nettype none
module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/pfb_front.sv =====
// Front end: accepts items, turns them into byte-walk operations, and queues them.
// Depends on pfb_pkg.
`default_nettype none
module pfb_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire pfb_pkg::in_item_t item,
	input wire logic clearing,
	output logic q_valid,
	output pfb_pkg::op_t q_op,
	input wire logic q_pop
);
	pfb_pkg::op_t op;
	logic keep;
	logic on;
	logic [3:0] bc;
	logic [6:0] rend;
	logic [5:0] r0;
	logic [5:0] r1;
	logic [7:0] lowmask;
	logic [8:0] lowmask9;
	pfb_pkg::op_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	always_comb begin
		on = |item.value;
		bc = (item.bit_count > 4'd8) ? 4'd8 : item.bit_count;
		rend = {1'b0, item.row_from} + {3'b0, bc} - 7'd1;
		lowmask9 = (9'd1 << bc) - 9'd1;
		lowmask = lowmask9[7:0];
		r0 = item.row_from;
		r1 = item.row_from;
		keep = 1'b1;
		op = '0;
		op.c0 = item.col_from;
		op.c1 = item.col_from;
		op.data16 = {16{on}};
		unique case (item.kind)
			pfb_pkg::KIND_DOT: begin
			end
			pfb_pkg::KIND_COLUMN: begin
				keep = (bc != 4'd0);
				r1 = (rend > 7'd63) ? 6'd63 : rend[5:0];
				op.data16 = {8'h00, item.value & lowmask} << item.row_from[2:0];
			end
			pfb_pkg::KIND_RECT: begin
				keep = (item.row_to >= item.row_from) && (item.col_to >= item.col_from);
				r1 = item.row_to;
				op.c1 = item.col_to;
			end
			pfb_pkg::KIND_FLUSH: begin
				keep = (item.col_to >= item.col_from);
				op.flush = 1'b1;
				op.c1 = item.col_to;
			end
			default: begin
			end
		endcase
		op.p0 = r0[5:3];
		op.p1 = r1[5:3];
		op.lo0 = r0[2:0];
		op.hi1 = r1[2:0];
		if (op.flush) begin
			op.p0 = item.page;
			op.p1 = item.page;
		end
	end

	assign item_stall = clearing || (count_q == 2'd2);
	assign push = item_valid && !item_stall && keep;
	assign q_valid = (count_q != 2'd0);
	assign q_op = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/pfb_back.sv =====
// Back end: clears the frame store after reset, then runs queued operations
// byte by byte against it and registers flush results. Depends on pfb_pkg, pfb_ram.
`default_nettype none
module pfb_back (
	input wire logic clk,
	input wire logic arst_n,
	output logic clearing,
	input wire logic q_valid,
	input wire pfb_pkg::op_t q_op,
	output logic q_pop,
	output logic result_valid,
	input wire logic result_stall,
	output pfb_pkg::out_item_t result
);
	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_WR_RD = 7'b0000100,
		S_WR_WB = 7'b0001000,
		S_FL_RD = 7'b0010000,
		S_FL_CAP = 7'b0100000,
		S_FL_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	pfb_pkg::op_t op_q;
	logic [pfb_pkg::PAGE_W-1:0] page_q;
	logic [pfb_pkg::COL_W-1:0] col_q;
	logic [pfb_pkg::COL_W-1:0] fcol_q;
	logic [2:0] k_q;
	logic last_q;
	logic [63:0] data_q;
	logic [pfb_pkg::ADDR_W-1:0] clr_q;
	logic res_valid_q;
	pfb_pkg::out_item_t res_q;

	logic we;
	logic [pfb_pkg::ADDR_W-1:0] waddr;
	logic [7:0] wdata;
	logic [7:0] rdata;
	logic [2:0] lo;
	logic [2:0] hi;
	logic [7:0] mask;
	logic [7:0] dbyte;
	logic out_free;
	logic load;

	pfb_ram #(.WIDTH(8), .DEPTH(pfb_pkg::DEPTH)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr({page_q, col_q}),
		.rdata(rdata)
	);

	always_comb begin
		lo = (page_q == op_q.p0) ? op_q.lo0 : 3'd0;
		hi = (page_q == op_q.p1) ? op_q.hi1 : 3'd7;
		mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
		dbyte = (page_q == op_q.p0) ? op_q.data16[7:0] : op_q.data16[15:8];
		we = 1'b0;
		waddr = {page_q, col_q};
		wdata = (rdata & ~mask) | (dbyte & mask);
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = 8'h00;
		end else if (state_q == S_WR_WB) begin
			we = 1'b1;
		end
	end

	assign clearing = (state_q == S_CLEAR);
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_free = !res_valid_q || !result_stall;
	assign load = (state_q == S_FL_OUT) && out_free;
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
		end
		if (state_q == S_FL_CAP) begin
			if (k_q == 3'd0) begin
				data_q <= {56'd0, rdata};
				fcol_q <= col_q;
			end else begin
				data_q <= data_q | ({56'd0, rdata} << {k_q, 3'd0});
			end
			last_q <= (col_q == op_q.c1);
		end
		if (load) begin
			res_q.out_page <= page_q;
			res_q.first_col <= fcol_q;
			res_q.byte_count <= {1'b0, k_q} + 4'd1;
			res_q.data <= data_q;
			res_q.last <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			page_q <= '0;
			col_q <= '0;
			k_q <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						page_q <= q_op.p0;
						col_q <= q_op.c0;
						k_q <= 3'd0;
						state_q <= q_op.flush ? S_FL_RD : S_WR_RD;
					end
				end
				S_WR_RD: begin
					state_q <= S_WR_WB;
				end
				S_WR_WB: begin
					if (col_q == op_q.c1) begin
						if (page_q == op_q.p1) begin
							state_q <= S_IDLE;
						end else begin
							page_q <= page_q + 1'b1;
							col_q <= op_q.c0;
							state_q <= S_WR_RD;
						end
					end else begin
						col_q <= col_q + 1'b1;
						state_q <= S_WR_RD;
					end
				end
				S_FL_RD: begin
					state_q <= S_FL_CAP;
				end
				S_FL_CAP: begin
					if ((col_q == op_q.c1) || (k_q == 3'd7)) begin
						state_q <= S_FL_OUT;
					end else begin
						col_q <= col_q + 1'b1;
						k_q <= k_q + 3'd1;
						state_q <= S_FL_RD;
					end
				end
				S_FL_OUT: begin
					if (out_free) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							col_q <= col_q + 1'b1;
							k_q <= 3'd0;
							state_q <= S_FL_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/page_framebuffer_draw_engine_top.sv =====
// Page frame buffer draw engine: 64 x 128 monochrome store, drawn and flushed.
// Each item is dispatched from the idle state; dots, column writes and rectangles then read
// and write back each touched byte, and flushes read each byte and load each result when
// the output is free. A two-entry queue decouples acceptance from the sequencer.
// After reset the store is cleared; items are stalled meanwhile.
`default_nettype none
`include "page_framebuffer_draw_engine_top_macros.svh"
module page_framebuffer_draw_engine_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire pfb_pkg::in_item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output pfb_pkg::out_item_t result
);
	logic clearing;
	logic q_valid;
	logic q_pop;
	pfb_pkg::op_t q_op;

	pfb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.clearing(clearing),
		.q_valid(q_valid),
		.q_op(q_op),
		.q_pop(q_pop)
	);

	pfb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.clearing(clearing),
		.q_valid(q_valid),
		.q_op(q_op),
		.q_pop(q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	`PFB_ASSERT_IMP(a_pop_needs_entry, q_pop, q_valid)
	`PFB_ASSERT_IMP(a_no_pop_clearing, clearing, !q_pop)
	`PFB_ASSERT_IMP(a_stall_clearing, clearing, item_stall)
	`PFB_ASSERT_NXT(a_pop_blocks_next, q_pop, !q_pop)
endmodule
`default_nettype wire

// ===== bench/tb_page_framebuffer_draw_engine_top.sv =====
// Self-checking bench for the page frame buffer draw engine: directed and random draw and flush items
// are checked against a local model of the 64 x 128 frame store.
// Depends on pfb_pkg and page_framebuffer_draw_engine_top.
`timescale 1ns / 100ps
`default_nettype none

class frame_scoreboard;
	logic [7:0] store [pfb_pkg::DEPTH];
	pfb_pkg::out_item_t flush_q [$];
	int errors;

	function void clear_store();
		foreach (store[i]) store[i] = 8'h00;
		flush_q.delete();
		errors = 0;
	endfunction

	function void put_pixel(int row, int col, bit on);
		int idx;
		if (row >= pfb_pkg::PAGES * 8 || col >= pfb_pkg::COLUMNS)
			return;
		idx = (row / 8) * pfb_pkg::COLUMNS + col;
		store[idx][row % 8] = on;
	endfunction

	function void note_item(pfb_pkg::in_item_t it);
		int cnt;
		int c1;
		int col;
		int n;
		pfb_pkg::out_item_t r;
		case (it.kind)
			pfb_pkg::KIND_DOT: put_pixel(it.row_from, it.col_from, it.value != 0);
			pfb_pkg::KIND_COLUMN: begin
				cnt = (it.bit_count > 8) ? 8 : it.bit_count;
				for (int i = 0; i < cnt; i++)
					put_pixel(it.row_from + i, it.col_from, it.value[i]);
			end
			pfb_pkg::KIND_RECT: begin
				if (it.row_to >= it.row_from && it.col_to >= it.col_from)
					for (int rr = it.row_from; rr <= it.row_to; rr++)
						for (int cc = it.col_from; cc <= it.col_to; cc++)
							put_pixel(rr, cc, it.value != 0);
			end
			default: begin
				c1 = it.col_to;
				if (it.page < pfb_pkg::PAGES && it.col_from < pfb_pkg::COLUMNS
						&& c1 >= it.col_from) begin
					if (c1 >= pfb_pkg::COLUMNS)
						c1 = pfb_pkg::COLUMNS - 1;
					col = it.col_from;
					while (col <= c1) begin
						n = (c1 - col + 1 > 8) ? 8 : c1 - col + 1;
						r = '0;
						r.out_page = it.page;
						r.first_col = 7'(col);
						r.byte_count = 4'(n);
						for (int k = 0; k < n; k++)
							r.data[8*k +: 8] = store[it.page * pfb_pkg::COLUMNS + col + k];
						r.last = (col + n > c1);
						flush_q.push_back(r);
						col += n;
					end
				end
			end
		endcase
	endfunction

	function void check_result(pfb_pkg::out_item_t got);
		pfb_pkg::out_item_t exp_r;
		if (flush_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		exp_r = flush_q.pop_front();
		if (got.out_page !== exp_r.out_page || got.first_col !== exp_r.first_col
				|| got.byte_count !== exp_r.byte_count || got.data !== exp_r.data
				|| got.last !== exp_r.last) begin
			$display("%0t: mismatch, expected %h, actual %h", $time, exp_r, got);
			errors++;
		end
	endfunction
endclass

module tb_page_framebuffer_draw_engine_top;
	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	pfb_pkg::in_item_t item;
	logic result_valid;
	logic result_stall;
	pfb_pkg::out_item_t result;

	frame_scoreboard sb;
	bit quiet;
	bit hold_off;
	int idle_cycles;

	page_framebuffer_draw_engine_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic pfb_pkg::in_item_t random_item();
		pfb_pkg::in_item_t it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = raw[$bits(pfb_pkg::in_item_t)-1:0];
		if ($urandom_range(0, 3) != 0) begin
			it.bit_count = 4'($urandom_range(1, 8));
			if (it.kind == pfb_pkg::KIND_RECT && $urandom_range(0, 5) != 0) begin
				it.row_to = 6'(it.row_from + $urandom_range(0, 7));
				if (it.row_to < it.row_from)
					it.row_to = 6'd63;
				it.col_to = 7'(it.col_from + $urandom_range(0, 20));
				if (it.col_to < it.col_from)
					it.col_to = 7'd127;
			end
			if (it.kind == pfb_pkg::KIND_FLUSH && $urandom_range(0, 3) != 0)
				it.col_to = 7'(it.col_from + $urandom_range(0, 40));
		end
		return it;
	endfunction

	function automatic pfb_pkg::in_item_t make_item(logic [1:0] k, int r0, int r1, int c0,
			int c1, int v, int bc, int pg);
		pfb_pkg::in_item_t it;
		it.kind = k;
		it.row_from = 6'(r0);
		it.row_to = 6'(r1);
		it.col_from = 7'(c0);
		it.col_to = 7'(c1);
		it.value = 8'(v);
		it.bit_count = 4'(bc);
		it.page = 3'(pg);
		return it;
	endfunction

	task automatic send_item(pfb_pkg::in_item_t it, bit allow_gap);
		int gap;
		if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	initial begin
		int burst;
		result_stall <= 1'b0;
		wait (arst_n);
		do @(posedge clk); while (!(item_valid && !item_stall));
		hold_off = 1'b1;
		result_stall <= 1'b1;
		repeat (300) @(posedge clk);
		result_stall <= 1'b0;
		hold_off = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				burst = $urandom_range(1, 12);
				repeat (burst) @(posedge clk);
			end
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		sb = new();
		sb.clear_store();
		quiet = 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 0, 127, 0, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_DOT, 0, 0, 0, 0, 1, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_DOT, 63, 0, 127, 0, 255, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_DOT, 5, 0, 3, 0, 0, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_COLUMN, 5, 0, 10, 0, 8'hA5, 8, 0), 0);
		send_item(make_item(pfb_pkg::KIND_COLUMN, 60, 0, 11, 0, 8'hFF, 8, 0), 0);
		send_item(make_item(pfb_pkg::KIND_COLUMN, 2, 0, 12, 0, 8'hFF, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_COLUMN, 3, 0, 13, 0, 8'h5A, 15, 0), 0);
		send_item(make_item(pfb_pkg::KIND_COLUMN, 0, 0, 14, 0, 8'h01, 1, 0), 0);
		send_item(make_item(pfb_pkg::KIND_RECT, 6, 20, 30, 45, 1, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_RECT, 10, 12, 32, 40, 0, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_RECT, 20, 6, 30, 45, 1, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_RECT, 6, 20, 45, 30, 1, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_RECT, 56, 63, 120, 127, 1, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 0, 127, 0, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 0, 127, 0, 0, 1), 0);
		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 120, 127, 0, 0, 7), 0);
		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 127, 127, 0, 0, 7), 0);
		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 40, 30, 0, 0, 2), 0);
		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 28, 37, 0, 0, 2), 0);
		send_item(make_item(pfb_pkg::KIND_RECT, 0, 63, 0, 127, 1, 0, 0), 0);
		send_item(make_item(pfb_pkg::KIND_FLUSH, 0, 0, 3, 17, 0, 0, 4), 0);

		for (int n = 0; n < 290; n++) begin
			if (n == 250)
				quiet = 1'b1;
			send_item(random_item(), 1);
		end
		item_valid <= 1'b0;

		while (sb.flush_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.flush_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/pfb_pkg.sv
sv/pfb_ram.sv
sv/pfb_front.sv
sv/pfb_back.sv
sv/page_framebuffer_draw_engine_top.sv
bench/tb_page_framebuffer_draw_engine_top.sv
